FILE: rtl/core/round_robin_tick_scheduler_defines.svh
// assertion macros shared by the scheduler modules
// needs nothing; taken in by the files that carry assertions
`ifndef ROUND_ROBIN_TICK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_DEFINES_SVH

// implication in the same cycle, quiet while in reset
`define RRTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication into the next cycle, quiet while in reset
`define RRTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/rrts_pkg.sv
// types and constants for the round-robin tick scheduler
// no dependencies; used by every module of the block
package rrts_pkg;

	localparam int ID_W        = 8;
	localparam int ID_SPACE    = 256;
	localparam int ARR_BURST_W = 32;
	localparam int RUN_W       = 9;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 8;
	localparam int TIME_W      = 32;

	localparam logic [RUN_W-1:0]     IDLE_CODE       = '1;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ_LIMIT   = 8'd1;
	localparam logic [CFG_W-1:0]     QUANTUM_RESET   = 32'd1;
	localparam logic [CFG_W-1:0]     SEQ_LIMIT_RESET = '1;

	typedef struct packed {
		logic                   has_arrival;
		logic [ID_W-1:0]        arrival_id;
		logic [ARR_BURST_W-1:0] arrival_burst;
	} tick_t;

	typedef struct packed {
		logic signed [RUN_W-1:0] running_id;
		logic                    seq_emit;
		logic                    first_start;
		logic                    finished;
		logic [ID_W-1:0]         finished_id;
		logic                    arrival_dropped;
		logic [TIME_W-1:0]       time_now;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic eval;
		logic swap;
		logic arrive;
		logic pop;
		logic dispatch;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic preempt;
		logic can_pop;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/core/rrts_ctrl.sv
// sequencer for one tick: evaluate, swap, enqueue, dispatch, publish
// depends on rrts_pkg for the command and status types
`include "round_robin_tick_scheduler_defines.svh"

module rrts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_valid,
	output logic             tick_stall,
	input  rrts_pkg::status_t status,
	output rrts_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_SWAP = 3'd2;
	localparam logic [2:0] S_ARR  = 3'd3;
	localparam logic [2:0] S_POP  = 3'd4;
	localparam logic [2:0] S_DISP = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign tick_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (tick_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = status.preempt ? S_SWAP : S_ARR;
			end
			S_SWAP: begin
				cmd.swap = 1'b1;
				state_d  = S_ARR;
			end
			S_ARR: begin
				cmd.arrive = 1'b1;
				state_d    = S_POP;
			end
			S_POP: begin
				if (status.can_pop) begin
					cmd.pop = 1'b1;
					state_d = S_DISP;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DISP: begin
				cmd.dispatch = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				// wait here while the previous result has not been taken
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`RRTS_ASSERT_NXT(a_accept_eval, clk, arst_n, tick_valid && !tick_stall, state_q == S_EVAL, "accepted tick not evaluated")
	`RRTS_ASSERT_IMP(a_cmd_single, clk, arst_n, 1'b1, $onehot0(cmd), "more than one datapath command")
	`RRTS_ASSERT_IMP(a_disp_after_pop, clk, arst_n, state_q == S_DISP, $past(state_q) == S_POP, "dispatch without a pop")

endmodule

FILE: rtl/core/rrts_dpath.sv
// scheduler datapath: cpu registers, ready queue memory, started map, result register
// depends on rrts_pkg; driven by rrts_ctrl commands
`include "round_robin_tick_scheduler_defines.svh"

module rrts_dpath #(
	parameter int MAX_TASKS   = 256,
	parameter int BURST_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rrts_pkg::cmd_t              cmd,
	output rrts_pkg::status_t           status,
	input  rrts_pkg::tick_t             tick_data,
	input  logic [rrts_pkg::CFG_W-1:0]  quantum,
	input  logic [rrts_pkg::CFG_W-1:0]  seq_limit,
	input  logic                        result_stall,
	output logic                        result_valid,
	output rrts_pkg::result_t           result_data
);

	localparam int PTR_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W   = $clog2(MAX_TASKS + 1);
	localparam int ENTRY_W = rrts_pkg::ID_W + BURST_WIDTH;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(MAX_TASKS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_TASKS);

	rrts_pkg::tick_t in_q;

	logic                          busy_q;
	logic [rrts_pkg::ID_W-1:0]     id_q;
	logic [BURST_WIDTH-1:0]        rem_q;
	logic [rrts_pkg::CFG_W-1:0]    slice_q;
	logic [rrts_pkg::TIME_W-1:0]   tick_q;
	logic [PTR_W-1:0]              head_q;
	logic [PTR_W-1:0]              tail_q;
	logic [CNT_W-1:0]              count_q;
	logic [rrts_pkg::ID_SPACE-1:0] started_q;
	logic [rrts_pkg::RUN_W-1:0]    last_q;
	logic [rrts_pkg::CFG_W-1:0]    emitted_q;

	logic                      fin_q;
	logic [rrts_pkg::ID_W-1:0] fin_id_q;
	logic                      first_q;
	logic                      drop_q;

	logic [ENTRY_W-1:0] ready_mem [MAX_TASKS];
	logic [ENTRY_W-1:0] rd_q;

	logic                       result_valid_q;
	rrts_pkg::result_t          result_q;

	logic                       fin_now;
	logic                       push_arr;
	logic                       mem_we;
	logic                       mem_re;
	logic [PTR_W-1:0]           mem_addr;
	logic [ENTRY_W-1:0]         mem_wdata;
	logic [63:0]                arr_burst_ext;
	logic [BURST_WIDTH-1:0]     arr_burst;
	logic [rrts_pkg::ID_W-1:0]  rd_id;
	logic [BURST_WIDTH-1:0]     rd_burst;
	logic [rrts_pkg::RUN_W-1:0] run_code;
	logic                       emit;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	assign arr_burst_ext = 64'(in_q.arrival_burst);
	assign arr_burst     = arr_burst_ext[BURST_WIDTH-1:0];
	assign rd_id         = rd_q[ENTRY_W-1 -: rrts_pkg::ID_W];
	assign rd_burst      = rd_q[BURST_WIDTH-1:0];

	assign fin_now = busy_q && (rem_q == '0);

	assign status.preempt  = busy_q && (rem_q != '0) && (slice_q >= quantum) && (count_q != '0);
	assign status.can_pop  = !busy_q && (count_q != '0);
	assign status.out_free = !result_valid_q || !result_stall;

	// single port: a swap or arrival write, or a head read
	assign push_arr  = cmd.arrive && in_q.has_arrival && (count_q != FULL_CNT);
	assign mem_we    = cmd.swap || push_arr;
	assign mem_re    = (cmd.eval && status.preempt) || cmd.pop;
	assign mem_addr  = mem_we ? tail_q : head_q;
	assign mem_wdata = cmd.swap ? {id_q, rem_q} : {in_q.arrival_id, arr_burst};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ready_mem[mem_addr] <= mem_wdata;
		end else if (mem_re) begin
			rd_q <= ready_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= tick_data;
		end
	end

	assign run_code = busy_q ? {1'b0, id_q} : rrts_pkg::IDLE_CODE;
	assign emit     = ((emitted_q == '0) || (last_q != run_code)) && (emitted_q < seq_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			id_q      <= '0;
			rem_q     <= '0;
			slice_q   <= '0;
			tick_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			started_q <= '0;
			last_q    <= rrts_pkg::IDLE_CODE;
			emitted_q <= '0;
			fin_q     <= 1'b0;
			fin_id_q  <= '0;
			first_q   <= 1'b0;
			drop_q    <= 1'b0;
		end else begin
			priority if (cmd.load) begin
				fin_q    <= 1'b0;
				fin_id_q <= '0;
				first_q  <= 1'b0;
				drop_q   <= 1'b0;
			end else if (cmd.eval) begin
				if (fin_now) begin
					fin_q    <= 1'b1;
					fin_id_q <= id_q;
					busy_q   <= 1'b0;
					slice_q  <= '0;
				end else if (status.preempt) begin
					head_q  <= next_slot(head_q);
					count_q <= count_q - 1'b1;
				end
			end else if (cmd.swap || cmd.dispatch) begin
				if (cmd.swap) begin
					// running task goes back to the tail
					tail_q  <= next_slot(tail_q);
					count_q <= count_q + 1'b1;
				end
				busy_q  <= 1'b1;
				id_q    <= rd_id;
				rem_q   <= rd_burst;
				slice_q <= '0;
				first_q <= !started_q[rd_id];
				started_q[rd_id] <= 1'b1;
			end else if (cmd.arrive) begin
				if (push_arr) begin
					tail_q  <= next_slot(tail_q);
					count_q <= count_q + 1'b1;
				end else if (in_q.has_arrival) begin
					drop_q <= 1'b1;
				end
			end else if (cmd.pop) begin
				head_q  <= next_slot(head_q);
				count_q <= count_q - 1'b1;
			end else if (cmd.commit) begin
				if (emit) begin
					last_q    <= run_code;
					emitted_q <= emitted_q + 1'b1;
				end
				if (busy_q && (rem_q != '0)) begin
					rem_q <= rem_q - 1'b1;
				end
				tick_q <= tick_q + 1'b1;
				if (slice_q != '1) begin
					slice_q <= slice_q + 1'b1;
				end
			end
		end
	end

	// result register, parts the tick sequencer from the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.running_id      <= run_code;
			result_q.seq_emit        <= emit;
			result_q.first_start     <= first_q && busy_q;
			result_q.finished        <= fin_q;
			result_q.finished_id     <= fin_id_q;
			result_q.arrival_dropped <= drop_q;
			result_q.time_now        <= tick_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	`RRTS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_CNT, "ready count beyond depth")
	`RRTS_ASSERT_IMP(a_port_single, clk, arst_n, mem_we, !mem_re, "queue memory read and write together")
	`RRTS_ASSERT_NXT(a_commit_time, clk, arst_n, cmd.commit, result_valid_q && (tick_q == $past(tick_q) + 1'b1), "commit did not publish and advance time")

endmodule

FILE: rtl/core/round_robin_tick_scheduler.sv
// round-robin time-slice scheduler, top level: configuration registers and wiring
// depends on rrts_pkg, rrts_ctrl and rrts_dpath
//
// usage:
//   tick channel (tick_valid, tick_stall, tick_data): one transfer per time tick, with an
//   optional arriving task (id, burst). result channel (result_valid, result_stall,
//   result_data): one transfer per tick giving the running id (-1 idle), first start,
//   finish event, condensed schedule emit, dropped arrival and tick number.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 quantum, index 1
//   seq_limit; other indexes are ignored. write only while no tick is in flight.
// tick sequence:
//   after a tick transfer the controller steps through evaluate, enqueue, pop and
//   result, with a swap step when the running task is preempted or a dispatch step
//   when an idle cpu takes the queue head (never both in one tick). the next tick is
//   taken in the idle state after the result is registered, so a tick is through
//   before the next is taken. the single-port ready queue memory serves one read or
//   write a cycle, up to three per tick. tick_stall is low only between ticks.
// reset: cpu idle, queue empty, started map cleared, time zero, quantum 1, limit all ones.
//   no clearing pass; the queue memory is only read where it was written.
// stall: a finished result waits in the output register; the next tick is still taken
//   and processed up to its result step, which waits until the held result is transferred.
module round_robin_tick_scheduler #(
	parameter int MAX_TASKS   = 256,
	parameter int BURST_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_stall,
	input  rrts_pkg::tick_t               tick_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output rrts_pkg::result_t             result_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrts_pkg::CFG_W-1:0]     cfg_data
);

	logic [rrts_pkg::CFG_W-1:0] quantum_q;
	logic [rrts_pkg::CFG_W-1:0] seq_limit_q;
	rrts_pkg::cmd_t             cmd;
	rrts_pkg::status_t          status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= rrts_pkg::QUANTUM_RESET;
			seq_limit_q <= rrts_pkg::SEQ_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == rrts_pkg::REG_QUANTUM) begin
				quantum_q <= cfg_data;
			end
			if (cfg_index == rrts_pkg::REG_SEQ_LIMIT) begin
				seq_limit_q <= cfg_data;
			end
		end
	end

	rrts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.status     (status),
		.cmd        (cmd)
	);

	rrts_dpath #(
		.MAX_TASKS   (MAX_TASKS),
		.BURST_WIDTH (BURST_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.tick_data    (tick_data),
		.quantum      (quantum_q),
		.seq_limit    (seq_limit_q),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_data  (result_data)
	);

endmodule

FILE: tb/tb.sv
// self-checking testbench for round_robin_tick_scheduler: random and directed tick transfers
// checked against a cycle-free scheduling predictor kept in this file
// depends on rrts_pkg and the round_robin_tick_scheduler rtl
`timescale 1ns / 1ps

module tb;

	localparam int READY_DEPTH = 256;
	localparam logic [rrts_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

	typedef struct packed {
		logic [rrts_pkg::ID_W-1:0]        id;
		logic [rrts_pkg::ARR_BURST_W-1:0] burst;
	} queued_task_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_valid = 1'b0;
	logic tick_stall;
	rrts_pkg::tick_t tick_data = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	rrts_pkg::result_t result_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rrts_pkg::CFG_W-1:0] cfg_data = '0;

	rrts_pkg::tick_t pending_ticks[$];
	rrts_pkg::result_t results_due[$];
	logic tick_fire = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;

	// scheduler state as the predictor sees it
	logic [rrts_pkg::CFG_W-1:0] slice_len = rrts_pkg::QUANTUM_RESET;
	logic [rrts_pkg::CFG_W-1:0] entry_cap = rrts_pkg::SEQ_LIMIT_RESET;
	logic on_cpu = 1'b0;
	logic [rrts_pkg::ID_W-1:0] cpu_owner = '0;
	logic [rrts_pkg::ARR_BURST_W-1:0] owner_left = '0;
	logic [31:0] slice_ticks = '0;
	logic [rrts_pkg::TIME_W-1:0] tick_no = '0;
	queued_task_t ready_tasks[$];
	logic [rrts_pkg::ID_SPACE-1:0] ever_ran = '0;
	logic [rrts_pkg::RUN_W-1:0] last_entry = rrts_pkg::IDLE_CODE;
	logic [31:0] entries_out = '0;

	round_robin_tick_scheduler #(
		.MAX_TASKS(READY_DEPTH),
		.BURST_WIDTH(rrts_pkg::ARR_BURST_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick_data(tick_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// returns 1 when the task has never held the cpu before
	function automatic logic put_on_cpu(queued_task_t t);
		logic fresh;
		fresh = !ever_ran[t.id];
		ever_ran[t.id] = 1'b1;
		on_cpu = 1'b1;
		cpu_owner = t.id;
		owner_left = t.burst;
		slice_ticks = '0;
		return fresh;
	endfunction

	function automatic rrts_pkg::result_t advance_tick(rrts_pkg::tick_t t);
		rrts_pkg::result_t r;
		queued_task_t head;
		queued_task_t parked;
		queued_task_t arriving;
		logic [rrts_pkg::RUN_W-1:0] run_code;
		r = '0;
		if (on_cpu && owner_left == 0) begin
			r.finished = 1'b1;
			r.finished_id = cpu_owner;
			on_cpu = 1'b0;
			slice_ticks = '0;
		end else if (on_cpu && slice_ticks >= slice_len && ready_tasks.size() > 0) begin
			// head leaves before the preempted task goes in, so a full queue still swaps
			head = ready_tasks.pop_front();
			parked.id = cpu_owner;
			parked.burst = owner_left;
			ready_tasks.insert(ready_tasks.size(), parked);
			r.first_start = put_on_cpu(head);
		end
		if (t.has_arrival) begin
			if (ready_tasks.size() < READY_DEPTH) begin
				arriving.id = t.arrival_id;
				arriving.burst = t.arrival_burst;
				ready_tasks.insert(ready_tasks.size(), arriving);
			end else begin
				r.arrival_dropped = 1'b1;
			end
		end
		if (!on_cpu && ready_tasks.size() > 0)
			r.first_start = put_on_cpu(ready_tasks.pop_front());
		run_code = on_cpu ? rrts_pkg::RUN_W'(cpu_owner) : rrts_pkg::IDLE_CODE;
		if ((entries_out == 0 || last_entry != run_code) && entries_out < entry_cap) begin
			r.seq_emit = 1'b1;
			last_entry = run_code;
			entries_out++;
		end
		r.running_id = run_code;
		r.time_now = tick_no;
		if (on_cpu && owner_left != 0)
			owner_left--;
		tick_no++;
		if (slice_ticks != '1)
			slice_ticks++;
		return r;
	endfunction

	function automatic rrts_pkg::tick_t make_tick(int arrive_pct, int burst_hi, int huge_pct);
		rrts_pkg::tick_t t;
		t.has_arrival = ($urandom_range(99) < arrive_pct);
		t.arrival_id = $urandom_range(255);
		if ($urandom_range(99) < huge_pct)
			t.arrival_burst = $urandom;
		else if ($urandom_range(3) == 0)
			t.arrival_burst = $urandom_range(burst_hi);
		else
			t.arrival_burst = $urandom_range(3);
		return t;
	endfunction

	task automatic queue_tick(input rrts_pkg::tick_t t);
		pending_ticks.insert(pending_ticks.size(), t);
	endtask

	task automatic add_tick(input logic arrives, input logic [rrts_pkg::ID_W-1:0] id,
			input logic [rrts_pkg::ARR_BURST_W-1:0] burst);
		rrts_pkg::tick_t t;
		t.has_arrival = arrives;
		t.arrival_id = id;
		t.arrival_burst = burst;
		queue_tick(t);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] at_tick,
			input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		$display("tick %0d: %s is %0h, expected %0h", at_tick, what, got, want);
	endtask

	task automatic write_reg(input logic [rrts_pkg::CFG_IDX_W-1:0] idx,
			input logic [rrts_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == rrts_pkg::REG_QUANTUM)
			slice_len = val;
		else if (idx == rrts_pkg::REG_SEQ_LIMIT)
			entry_cap = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_ticks.size() != 0 || tick_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// driver: next tick goes out once the previous transfer has happened
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n && (tick_fire || !tick_valid)) begin
			if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				tick_valid <= 1'b1;
				tick_data <= pending_ticks.pop_front();
			end else begin
				tick_valid <= 1'b0;
			end
		end
	end

	// monitor: predict on each tick transfer, check on each result transfer
	always @(posedge clk) begin
		rrts_pkg::result_t want;
		tick_fire <= arst_n && tick_valid && !tick_stall;
		if (arst_n) begin
			if (tick_valid && !tick_stall)
				results_due.insert(results_due.size(), advance_tick(tick_data));
			if (result_valid && !result_stall) begin
				if (results_due.size() == 0) begin
					report_mismatch("unexpected result, running_id", result_data.time_now,
						result_data.running_id, '0);
				end else begin
					want = results_due.pop_front();
					if (result_data.running_id !== want.running_id)
						report_mismatch("running_id", want.time_now,
							result_data.running_id, want.running_id);
					if (result_data.seq_emit !== want.seq_emit)
						report_mismatch("seq_emit", want.time_now,
							result_data.seq_emit, want.seq_emit);
					if (result_data.first_start !== want.first_start)
						report_mismatch("first_start", want.time_now,
							result_data.first_start, want.first_start);
					if (result_data.finished !== want.finished)
						report_mismatch("finished", want.time_now,
							result_data.finished, want.finished);
					if (result_data.finished_id !== want.finished_id)
						report_mismatch("finished_id", want.time_now,
							result_data.finished_id, want.finished_id);
					if (result_data.arrival_dropped !== want.arrival_dropped)
						report_mismatch("arrival_dropped", want.time_now,
							result_data.arrival_dropped, want.arrival_dropped);
					if (result_data.time_now !== want.time_now)
						report_mismatch("time_now", want.time_now,
							result_data.time_now, want.time_now);
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed ticks, slice of two
		send_idle_pct = 21;
		recv_idle_pct = 64;
		write_reg(rrts_pkg::REG_QUANTUM, 32'd2);
		write_reg(rrts_pkg::REG_SEQ_LIMIT, '1);
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		add_tick(1'b0, 8'hFF, '1);
		add_tick(1'b0, 8'h00, 32'd0);
		add_tick(1'b1, 8'h00, 32'd0);
		add_tick(1'b0, 8'h00, 32'd0);
		add_tick(1'b1, 8'hFF, 32'd3);
		add_tick(1'b1, 8'h55, 32'd2);
		add_tick(1'b1, 8'hAA, 32'd1);
		repeat (8) add_tick(1'b0, 8'h00, 32'd0);
		add_tick(1'b1, 8'h00, 32'd1);
		add_tick(1'b1, 8'h01, 32'd4);
		repeat (4) add_tick(1'b0, 8'h00, 32'd0);
		wait_idle();

		// slice of one, emission limit met part way through
		write_reg(rrts_pkg::REG_QUANTUM, 32'd1);
		write_reg(rrts_pkg::REG_SEQ_LIMIT, entries_out + 32'd40);
		repeat (350) queue_tick(make_tick(15, 24, 0));
		wait_idle();

		// no preemption behind a long task: ready queue fills and arrivals drop
		send_idle_pct = 64;
		recv_idle_pct = 21;
		write_reg(rrts_pkg::REG_QUANTUM, '1);
		write_reg(rrts_pkg::REG_SEQ_LIMIT, 32'd0);
		add_tick(1'b1, 8'h3C, 32'd290);
		repeat (290) queue_tick(make_tick(95, 3, 0));
		wait_idle();

		// zero slice: swap on every tick with an unfinished running task and a non-empty queue, starting from a full queue
		write_reg(rrts_pkg::REG_QUANTUM, 32'd0);
		write_reg(rrts_pkg::REG_SEQ_LIMIT, '1);
		repeat (150) queue_tick(make_tick(10, 24, 0));
		wait_idle();

		// back to back transfers, then huge bursts near the end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(rrts_pkg::REG_QUANTUM, $urandom_range(2, 6));
		repeat (400) queue_tick(make_tick(12, 24, 0));
		add_tick(1'b1, 8'hC3, '1);
		repeat (100) queue_tick(make_tick(12, 24, 5));
		wait_idle();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("round_robin_tick_scheduler test passed");
		else
			$display("round_robin_tick_scheduler test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("round_robin_tick_scheduler test failed");
		$finish;
	end

endmodule
